/* hdl/nearest_neighbor_tour_unit_assert.svh */
// assertion macros for the nearest-neighbor tour unit
`ifndef NEAREST_NEIGHBOR_TOUR_UNIT_ASSERT_SVH
`define NEAREST_NEIGHBOR_TOUR_UNIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define NNT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define NNT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/nnt_pkg.sv */
// shared types and constants of the nearest-neighbor tour unit
package nnt_pkg;
   localparam int MaxCitiesDefault = 64;
   localparam int CoordWidth       = 32;
   localparam int IndexWidth       = 6;
   localparam int LegWidth         = 34;
   localparam int TotalWidth       = 40;
   localparam int DiffWidth        = 33;
   localparam int SqWidth          = 65;
   localparam logic [TotalWidth-1:0] TotalMax = '1;

   // request to the square-root unit
   typedef struct packed {
      logic              start;
      logic [SqWidth-1:0] radicand;
   } sqrt_req_type;

   // answer of the square-root unit
   typedef struct packed {
      logic                done;
      logic [LegWidth-1:0] root;
   } sqrt_rsp_type;
endpackage

/* hdl/nnt_coord_mem.sv */
// coordinate memory: one write port, one registered read port
module nnt_coord_mem import nnt_pkg::*; #(
   parameter int MAX_CITIES = MaxCitiesDefault,
   localparam int AW = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  logic [2*CoordWidth-1:0] wr_data,
   input  logic [AW-1:0]           rd_addr,
   output logic [2*CoordWidth-1:0] rd_data
);
   logic [2*CoordWidth-1:0] mem [MAX_CITIES];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end
endmodule

/* hdl/nnt_isqrt.sv */
// iterative integer square root, one result bit per cycle
module nnt_isqrt import nnt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  sqrt_req_type req,
   output sqrt_rsp_type rsp
);
   localparam int Steps = (SqWidth + 1) / 2;
   localparam int CntW  = $clog2(Steps + 1);

   logic [SqWidth:0]     rad_ff, rad_in;
   logic [SqWidth+1:0]   rem_ff, rem_in;
   logic [LegWidth:0]    root_ff, root_in;
   logic [CntW-1:0]      cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [SqWidth+1:0]   rem_sh;
   logic [SqWidth+1:0]   trial;

   // one digit pair per step
   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[SqWidth-1:0], rad_ff[SqWidth:SqWidth-1]};
      trial   = {{(SqWidth+1-LegWidth-2){1'b0}}, root_ff, 2'b01};
      if (req.start) begin
         rad_in  = {1'b0, req.radicand};
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[SqWidth-2:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[LegWidth-1:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[LegWidth-1:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntW'(Steps - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign rsp.done = done_ff;
   assign rsp.root = root_ff[LegWidth-1:0];
endmodule

/* hdl/nearest_neighbor_tour_unit.sv */
// Nearest-neighbor tour unit: top level with scan sequencer and result register.
// Loading takes one city per cycle. Each of the n legs of a tour fetches the current
// city, scans the cities and drains the read pipeline, runs the bit-serial square root
// and posts the result, which rsp stalls can hold.
// Synchronous active-high reset clears control state; the coordinate memory
// is not cleared and needs no clearing pass.
`include "nearest_neighbor_tour_unit_assert.svh"
module nearest_neighbor_tour_unit import nnt_pkg::*; #(
   parameter int MAX_CITIES = MaxCitiesDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic signed [31:0]     req_x_coord,
   input  logic signed [31:0]     req_y_coord,
   input  logic                   req_last_city,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [IndexWidth-1:0]  rsp_city_index,
   output logic [LegWidth-1:0]    rsp_leg_length,
   output logic [TotalWidth-1:0]  rsp_tour_total,
   output logic                   rsp_tour_end
);
   localparam int AW = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
   localparam int CW = $clog2(MAX_CITIES + 1);

   typedef enum logic [6:0] {
      ST_LOAD  = 7'b0000001,
      ST_CUR   = 7'b0000010,
      ST_CURW  = 7'b0000100,
      ST_SCAN  = 7'b0001000,
      ST_SQRT  = 7'b0010000,
      ST_WAIT  = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   state_type             state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [MAX_CITIES-1:0] visited_ff, visited_in;
   logic [AW-1:0]         cur_ff, cur_in;
   logic [TotalWidth-1:0] sum_ff, sum_in;
   logic [CW-1:0]         steps_ff, steps_in;
   logic [CoordWidth-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [CW-1:0]         addr_ff, addr_in;
   logic                  rv_ff, rv_in;
   logic [AW-1:0]         raddr_ff, raddr_in;
   logic                  found_ff, found_in;
   logic [AW-1:0]         best_ff, best_in;
   logic [SqWidth-1:0]    bestd_ff, bestd_in;
   logic                  ret_ff, ret_in;
   logic                  ov_ff, ov_in;
   logic [IndexWidth-1:0] oidx_ff, oidx_in;
   logic [LegWidth-1:0]   oleg_ff, oleg_in;
   logic [TotalWidth-1:0] otot_ff, otot_in;
   logic                  oend_ff, oend_in;
   logic [DiffWidth-1:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic                  dv_ff, dv_in;
   logic [AW-1:0]         daddr_ff, daddr_in;
   logic [SqWidth-1:0]    cand_dist;
   logic [2*DiffWidth-1:0] sqx, sqy;
   logic [CoordWidth-1:0] mx, my;
   logic [DiffWidth-1:0]  ddx, ddy;
   logic [2*CoordWidth-1:0] rd_data;
   logic                  wr_en;
   logic [AW-1:0]         mem_rd;
   logic [TotalWidth:0]   sum_wide;
   sqrt_req_type          sq_req;
   sqrt_rsp_type          sq_rsp;

   assign wr_en = (state_ff == ST_LOAD) && req_valid
               && (count_ff < CW'(MAX_CITIES));

   nnt_coord_mem #(.MAX_CITIES(MAX_CITIES)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data ({req_x_coord, req_y_coord}),
      .rd_addr (mem_rd),
      .rd_data (rd_data)
   );

   nnt_isqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .req   (sq_req),
      .rsp   (sq_rsp)
   );

   // difference magnitudes of the word just read
   assign mx  = rd_data[2*CoordWidth-1:CoordWidth];
   assign my  = rd_data[CoordWidth-1:0];
   always_comb begin
      logic signed [DiffWidth-1:0] sx, sy;
      sx  = DiffWidth'($signed(mx)) - DiffWidth'($signed(cx_ff));
      sy  = DiffWidth'($signed(my)) - DiffWidth'($signed(cy_ff));
      ddx = sx[DiffWidth-1] ? DiffWidth'(-sx) : DiffWidth'(sx);
      ddy = sy[DiffWidth-1] ? DiffWidth'(-sy) : DiffWidth'(sy);
   end

   // squares of registered differences
   assign sqx  = dx_ff * dx_ff;
   assign sqy  = dy_ff * dy_ff;
   assign cand_dist = SqWidth'(sqx) + SqWidth'(sqy);
   assign sum_wide = {1'b0, sum_ff} + {{(TotalWidth+1-LegWidth){1'b0}}, sq_rsp.root};

   assign req_stall  = (state_ff != ST_LOAD);
   assign rsp_valid  = ov_ff;
   assign rsp_city_index = oidx_ff;
   assign rsp_leg_length = oleg_ff;
   assign rsp_tour_total = otot_ff;
   assign rsp_tour_end   = oend_ff;
   // read address goes to the memory in the cycle it is chosen
   assign mem_rd = raddr_in;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      visited_in = visited_ff;
      cur_in     = cur_ff;
      sum_in     = sum_ff;
      steps_in   = steps_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      addr_in    = addr_ff;
      rv_in      = 1'b0;
      raddr_in   = raddr_ff;
      found_in   = found_ff;
      best_in    = best_ff;
      bestd_in   = bestd_ff;
      ret_in     = ret_ff;
      ov_in      = ov_ff && rsp_stall;
      oidx_in    = oidx_ff;
      oleg_in    = oleg_ff;
      otot_in    = otot_ff;
      oend_in    = oend_ff;
      dx_in      = ddx;
      dy_in      = ddy;
      dv_in      = 1'b0;
      daddr_in   = daddr_ff;
      sq_req.start    = 1'b0;
      sq_req.radicand = bestd_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               if (count_ff < CW'(MAX_CITIES)) begin
                  count_in = count_ff + 1'b1;
               end
               if (req_last_city) begin
                  steps_in   = CW'(1);
                  visited_in = MAX_CITIES'(1);
                  cur_in     = '0;
                  sum_in     = '0;
                  raddr_in   = '0;
                  state_in   = ST_CUR;
               end
            end
         end
         ST_CUR: begin
            state_in = ST_CURW;
         end
         ST_CURW: begin
            cx_in    = mx;
            cy_in    = my;
            found_in = 1'b0;
            addr_in  = '0;
            ret_in   = (steps_ff >= count_ff);
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // issue reads for unvisited cities, or for city 0 on the return leg
            if (addr_ff < count_ff) begin
               if (ret_ff ? (addr_ff == '0) : !visited_ff[addr_ff[AW-1:0]]) begin
                  raddr_in = addr_ff[AW-1:0];
                  rv_in    = 1'b1;
               end
               addr_in = addr_ff + 1'b1;
            end
            // compare stage
            if (dv_ff && (!found_ff || cand_dist < bestd_ff)) begin
               found_in = 1'b1;
               best_in  = daddr_ff;
               bestd_in = cand_dist;
            end
            if (addr_ff >= count_ff && !rv_ff && !dv_ff) begin
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            sq_req.start = 1'b1;
            state_in     = ST_WAIT;
         end
         ST_WAIT: begin
            if (sq_rsp.done) begin
               sum_in   = sum_wide[TotalWidth] ? TotalMax : sum_wide[TotalWidth-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // load the result register once the previous transfer is gone
            if (!ov_ff || !rsp_stall) begin
               ov_in   = 1'b1;
               oleg_in = sq_rsp.root;
               otot_in = sum_ff;
               oidx_in = ret_ff ? '0 : IndexWidth'(best_ff);
               oend_in = ret_ff;
               if (ret_ff) begin
                  count_in   = '0;
                  visited_in = '0;
                  cur_in     = '0;
                  sum_in     = '0;
                  state_in   = ST_LOAD;
               end else begin
                  visited_in = visited_ff | (MAX_CITIES'(1) << best_ff);
                  cur_in     = best_ff;
                  raddr_in   = best_ff;
                  steps_in   = steps_ff + 1'b1;
                  state_in   = ST_CUR;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
      if (rv_ff) begin
         dv_in    = 1'b1;
         daddr_in = raddr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         count_ff   <= '0;
         visited_ff <= '0;
         cur_ff     <= '0;
         sum_ff     <= '0;
         rv_ff      <= 1'b0;
         dv_ff      <= 1'b0;
         ov_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         visited_ff <= visited_in;
         cur_ff     <= cur_in;
         sum_ff     <= sum_in;
         rv_ff      <= rv_in;
         dv_ff      <= dv_in;
         ov_ff      <= ov_in;
      end
      steps_ff <= steps_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      addr_ff  <= addr_in;
      raddr_ff <= raddr_in;
      found_ff <= found_in;
      best_ff  <= best_in;
      bestd_ff <= bestd_in;
      ret_ff   <= ret_in;
      oidx_ff  <= oidx_in;
      oleg_ff  <= oleg_in;
      otot_ff  <= otot_in;
      oend_ff  <= oend_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      daddr_ff <= daddr_in;
   end

   // checks
   `NNT_ASSERT_IMPL(a_no_load_in_tour, clock, reset, state_ff != ST_LOAD, req_stall, "input taken during tour")
   `NNT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_tour_total), "result dropped")
   `NNT_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(MAX_CITIES), "city count overflow")
endmodule
